FILE: design/glob_pattern_parser_defines.svh
// Assertion macros for the glob pattern parser.
// Needs nothing; included by the modules that check their own logic.
`ifndef GLOB_PATTERN_PARSER_DEFINES_SVH
`define GLOB_PATTERN_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define GPP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GPP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GPP_ASSERT(label, clk, rst_n, prop, msg)
`define GPP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: design/gpp_pkg.sv
// Shared types and constants for the glob pattern parser.
// No dependencies.
package gpp_pkg;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_STAR     = 8'h2A;
	localparam logic [7:0] CH_OPEN     = 8'h5B;
	localparam logic [7:0] CH_CLOSE    = 8'h5D;
	localparam logic [7:0] CH_BANG     = 8'h21;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_BSLASH   = 8'h5C;

	localparam logic [2:0] KIND_CHAR  = 3'd0;
	localparam logic [2:0] KIND_CLASS = 3'd1;
	localparam logic [2:0] KIND_NEG   = 3'd2;
	localparam logic [2:0] KIND_WILD  = 3'd3;
	localparam logic [2:0] KIND_GLOB  = 3'd4;

	// Back-end operation codes carried in the queue
	localparam logic [2:0] OP_NONE   = 3'd0; // emit nothing (end result only)
	localparam logic [2:0] OP_SIMPLE = 3'd1; // char / wildcard / glob atom
	localparam logic [2:0] OP_OPEN   = 3'd2; // clear set
	localparam logic [2:0] OP_ADD    = 3'd3; // add one member
	localparam logic [2:0] OP_RANGE  = 3'd4; // add inclusive signed range
	localparam logic [2:0] OP_ADDCLS = 3'd5; // add member then close class
	localparam logic [2:0] OP_CLOSE  = 3'd6; // close class

	localparam int QUEUE_DEPTH = 4;

	// Classified command from front to back
	typedef struct packed {
		logic [2:0] op;
		logic [2:0] kind;
		logic [7:0] lo;
		logic [7:0] hi;
		logic       emit;   // produces a result
		logic       fin;
		logic       valid;
	} cmd_t;
endpackage

FILE: design/glob_pattern_parser.sv
// Channel  | dir | handshake    | fields
// input    | in  | push / full  | char_byte, final_byte
// result   | out | pop / empty  | atom_present .. name_valid
// One byte per cycle while the queue is not full; a taken byte passes through the
// command queue and then the output register before its result is on the ports.
// The front phase machine decides each byte combinationally; the back end ORs one
// range mask into the 256-bit class set per command.
// A four-entry command queue lets the front keep accepting while results wait.
// Reset (arst_n low) clears phase, queue and result register at once.
// Top level of the glob pattern parser; uses gpp_pkg, gpp_front, gpp_queue, gpp_back.
module glob_pattern_parser import gpp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_byte,
	input  logic        final_byte,
	input  logic        pop,
	output logic        empty,
	output logic        atom_present,
	output logic [2:0]  atom_kind,
	output logic [7:0]  atom_char,
	output logic [63:0] set_bits_0,
	output logic [63:0] set_bits_1,
	output logic [63:0] set_bits_2,
	output logic [63:0] set_bits_3,
	output logic        name_end,
	output logic        name_valid
);
	cmd_t f_cmd, b_cmd;
	logic f_valid, q_full, q_empty, b_take;

	assign full = q_full;

	gpp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_take(push && !q_full),
		.in_char(char_byte), .in_fin(final_byte), .cmd(f_cmd), .cmd_valid(f_valid)
	);

	gpp_queue #(.DEPTH(DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(f_valid), .wr_cmd(f_cmd), .q_full(q_full),
		.rd_en(b_take), .rd_cmd(b_cmd), .q_empty(q_empty)
	);

	gpp_back u_back (
		.clk(clk), .arst_n(arst_n), .cmd(b_cmd), .cmd_avail(!q_empty), .cmd_take(b_take),
		.pop(pop), .empty(empty), .atom_present(atom_present), .atom_kind(atom_kind),
		.atom_char(atom_char), .set_bits_0(set_bits_0), .set_bits_1(set_bits_1),
		.set_bits_2(set_bits_2), .set_bits_3(set_bits_3), .name_end(name_end),
		.name_valid(name_valid)
	);
endmodule

FILE: design/gpp_front.sv
// Front end: byte-at-a-time phase machine that classifies bytes into commands.
// Depends on gpp_pkg.
module gpp_front import gpp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_take,
	input  logic [7:0] in_char,
	input  logic       in_fin,
	output cmd_t       cmd,
	output logic       cmd_valid
);
	localparam logic [3:0] PH_IDLE = 4'd0, PH_ESC_TOP = 4'd1, PH_CLASS_OPEN = 4'd2,
		PH_CLASS_FIRST = 4'd3, PH_TAIL = 4'd4, PH_ESC_ELEM = 4'd5, PH_PENDING = 4'd6,
		PH_RANGE_LAST = 4'd7, PH_ESC_LAST = 4'd8;

	logic [3:0] phase_q, ph_n;
	logic       neg_q, neg_n;
	logic [7:0] rs_q, rs_n;
	logic       ok_q, ok_n;
	logic [2:0] op;
	logic [2:0] kind;
	logic [7:0] lo, hi;
	logic       atom;

	// Next phase and command for one byte
	always_comb begin
		ph_n = phase_q;
		neg_n = neg_q;
		rs_n = rs_q;
		ok_n = ok_q;
		op = OP_NONE;
		kind = KIND_CHAR;
		lo = in_char;
		hi = in_char;
		atom = 1'b0;
		if (ok_q) begin
			case (phase_q)
				PH_ESC_TOP: begin
					op = OP_SIMPLE; atom = 1'b1; ph_n = PH_IDLE;
				end
				PH_CLASS_OPEN, PH_CLASS_FIRST: begin
					if (phase_q == PH_CLASS_OPEN && in_char == CH_BANG) begin
						neg_n = 1'b1; ph_n = PH_CLASS_FIRST;
					end else if (in_char == CH_BSLASH) begin
						ph_n = PH_ESC_ELEM;
					end else begin
						rs_n = in_char; ph_n = PH_PENDING;
					end
				end
				PH_TAIL: begin
					if (in_char == CH_CLOSE) begin
						op = OP_CLOSE; atom = 1'b1; ph_n = PH_IDLE;
						kind = neg_q ? KIND_NEG : KIND_CLASS;
					end else if (in_char == CH_BSLASH) begin
						ph_n = PH_ESC_ELEM;
					end else begin
						rs_n = in_char; ph_n = PH_PENDING;
					end
				end
				PH_ESC_ELEM: begin
					rs_n = in_char; ph_n = PH_PENDING;
				end
				PH_PENDING: begin
					lo = rs_q;
					hi = rs_q;
					if (in_char == CH_DASH) begin
						ph_n = PH_RANGE_LAST;
					end else if (in_char == CH_CLOSE) begin
						op = OP_ADDCLS; atom = 1'b1; ph_n = PH_IDLE;
						kind = neg_q ? KIND_NEG : KIND_CLASS;
					end else begin
						op = OP_ADD;
						if (in_char == CH_BSLASH) begin
							ph_n = PH_ESC_ELEM;
						end else begin
							rs_n = in_char; ph_n = PH_PENDING;
						end
					end
				end
				PH_RANGE_LAST, PH_ESC_LAST: begin
					if (phase_q == PH_RANGE_LAST && in_char == CH_BSLASH) begin
						ph_n = PH_ESC_LAST;
					end else if ($signed(rs_q) > $signed(in_char)) begin
						ok_n = 1'b0;
					end else begin
						op = OP_RANGE; lo = rs_q; hi = in_char; ph_n = PH_TAIL;
					end
				end
				default: begin
					// idle and unused codes
					ph_n = PH_IDLE;
					if (in_char == CH_QUESTION) begin
						op = OP_SIMPLE; atom = 1'b1; kind = KIND_WILD;
					end else if (in_char == CH_STAR) begin
						op = OP_SIMPLE; atom = 1'b1; kind = KIND_GLOB;
					end else if (in_char == CH_OPEN) begin
						op = OP_OPEN; neg_n = 1'b0; ph_n = PH_CLASS_OPEN;
					end else if (in_char == CH_BSLASH) begin
						ph_n = PH_ESC_TOP;
					end else begin
						op = OP_SIMPLE; atom = 1'b1;
					end
				end
			endcase
		end
		if (in_fin && ok_n && ph_n != PH_IDLE)
			ok_n = 1'b0;
		if (!ok_n) begin
			atom = 1'b0;
			if (op == OP_SIMPLE || op == OP_CLOSE || op == OP_ADDCLS)
				op = OP_NONE;
		end
	end

	assign cmd.op = op;
	assign cmd.kind = kind;
	assign cmd.lo = lo;
	assign cmd.hi = hi;
	assign cmd.emit = atom | in_fin;
	assign cmd.fin = in_fin;
	assign cmd.valid = ok_n;
	assign cmd_valid = in_take && (op != OP_NONE || in_fin);

	// Phase registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q <= 1'b0;
			rs_q <= '0;
			ok_q <= 1'b1;
		end else if (in_take) begin
			if (in_fin) begin
				phase_q <= PH_IDLE;
				neg_q <= 1'b0;
				rs_q <= '0;
				ok_q <= 1'b1;
			end else begin
				phase_q <= ph_n;
				neg_q <= neg_n;
				rs_q <= rs_n;
				ok_q <= ok_n;
			end
		end
	end
endmodule

FILE: design/gpp_queue.sv
// Short command queue between the front and back ends.
// Depends on gpp_pkg and the assertion macros.
`include "glob_pattern_parser_defines.svh"
module gpp_queue import gpp_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic q_full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic q_empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	cmd_t          mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	assign q_full = (cnt_q == (AW+1)'(DEPTH));
	assign q_empty = (cnt_q == '0);
	assign rd_cmd = mem_q[rp_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en && !q_full)
			mem_q[wp_q] <= wr_cmd;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en && !q_full)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (rd_en && !q_empty)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr_en && !q_full) - (AW+1)'(rd_en && !q_empty);
		end
	end

	`GPP_ASSERT(a_cnt_range, clk, arst_n, cnt_q <= (AW+1)'(DEPTH), "queue overfilled")
	`GPP_ASSERT(a_no_wr_full, clk, arst_n, !(wr_en && q_full), "write into full queue")
	`GPP_ASSERT(a_cnt_step, clk, arst_n,
		(rd_en && !q_empty && !wr_en) |=> cnt_q == $past(cnt_q) - 1'b1, "count slip")
endmodule

FILE: design/gpp_back.sv
// Back end: applies commands to the class set and builds result items.
// Depends on gpp_pkg and the assertion macros.
`include "glob_pattern_parser_defines.svh"
module gpp_back import gpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_avail,
	output logic        cmd_take,
	input  logic        pop,
	output logic        empty,
	output logic        atom_present,
	output logic [2:0]  atom_kind,
	output logic [7:0]  atom_char,
	output logic [63:0] set_bits_0,
	output logic [63:0] set_bits_1,
	output logic [63:0] set_bits_2,
	output logic [63:0] set_bits_3,
	output logic        name_end,
	output logic        name_valid
);
	logic [255:0] set_q, set_n, rmask;
	logic         out_v_q;
	logic         room;
	logic [7:0]   lo_b, hi_b;
	logic         is_simple, is_cls;

	// Range mask in offset order: flip sign bit so signed order becomes unsigned
	always_comb begin
		lo_b = cmd.lo ^ 8'h80;
		hi_b = cmd.hi ^ 8'h80;
		for (int i = 0; i < 256; i++) begin
			rmask[i ^ 128] = (8'(i) >= lo_b) && (8'(i) <= hi_b);
		end
	end

	always_comb begin
		set_n = set_q;
		case (cmd.op)
			OP_OPEN:  set_n = '0;
			OP_ADD, OP_ADDCLS, OP_RANGE: set_n = set_q | rmask;
			default:  set_n = set_q;
		endcase
	end

	assign room = !out_v_q || pop;
	assign cmd_take = cmd_avail && (!cmd.emit || room);
	assign empty = !out_v_q;

	// Which commands carry an atom
	assign is_simple = (cmd.op == OP_SIMPLE);
	assign is_cls = (cmd.op == OP_CLOSE) || (cmd.op == OP_ADDCLS);

	// Class set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			set_q <= '0;
		else if (cmd_take)
			set_q <= set_n;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd_take && cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd.emit) begin
			atom_present <= is_simple || is_cls;
			atom_kind <= (is_simple || is_cls) ? cmd.kind : 3'd0;
			atom_char <= (is_simple && cmd.kind == KIND_CHAR) ? cmd.lo : 8'd0;
			{set_bits_3, set_bits_2, set_bits_1, set_bits_0} <= is_cls ? set_n : '0;
			name_end <= cmd.fin;
			name_valid <= cmd.fin && cmd.valid;
		end
	end

	`GPP_ASSERT(a_take_room, clk, arst_n, (cmd_take && cmd.emit) |-> room,
		"result overwritten")
	`GPP_ASSERT(a_hold, clk, arst_n, (out_v_q && !pop) |=> out_v_q, "result lost")
endmodule

FILE: dv/tb_glob_pattern_parser.sv
// Testbench for the glob pattern parser: directed names, then random glob names.
// Depends on gpp_pkg and glob_pattern_parser; predicts atoms with its own parser.
module tb_glob_pattern_parser;
	import gpp_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_ESC_TOP, P_OPEN, P_FIRST, P_TAIL, P_ESC_MEM, P_PEND, P_RLAST, P_ESC_LAST
	} phase_t;

	typedef struct packed {
		logic        present;
		logic [2:0]  kind;
		logic [7:0]  ch;
		logic [255:0] set;
		logic        fin;
		logic        ok;
	} atom_t;

	typedef struct {
		logic [7:0] b;
		logic       fin;
		logic       chk;    // typed expectation present
		atom_t      want;
	} row_t;

	logic clk = 1'b0, arst_n = 1'b0, push = 1'b0, pop = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic final_byte = 1'b0;
	logic full, empty, atom_present, name_end, name_valid;
	logic [2:0] atom_kind;
	logic [7:0] atom_char;
	logic [63:0] set_bits_0, set_bits_1, set_bits_2, set_bits_3;

	glob_pattern_parser i_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	phase_t     ph;
	logic       neg, ok;
	logic [7:0] rstart;
	logic [255:0] cset;
	atom_t      atoms_due[$];
	int         errors = 0, n_items = 0, n_atoms = 0, n_names = 0;

	function automatic int sgn(logic [7:0] b);
		return b[7] ? int'(b) - 256 : int'(b);
	endfunction

	function automatic void start_member(logic [7:0] b);
		if (b == CH_BSLASH) ph = P_ESC_MEM;
		else begin
			rstart = b;
			ph = P_PEND;
		end
	endfunction

	function automatic void end_range(logic [7:0] last);
		int lo, hi;
		lo = sgn(rstart);
		hi = sgn(last);
		if (lo > hi) ok = 1'b0;
		else for (int v = lo; v <= hi; v++) cset[8'(v + 256)] = 1'b1;
		ph = P_TAIL;
	endfunction

	// Advances the parser by one byte; returns 1 with the atom when a result is due.
	function automatic bit parse_byte(logic [7:0] b, logic fin, output atom_t a);
		int kind;
		logic [7:0] ch;
		kind = -1;
		ch = 8'h00;
		if (ok) begin
			case (ph)
				P_IDLE: begin
					if (b == CH_QUESTION) kind = int'(KIND_WILD);
					else if (b == CH_STAR) kind = int'(KIND_GLOB);
					else if (b == CH_OPEN) begin
						cset = '0;
						neg = 1'b0;
						ph = P_OPEN;
					end else if (b == CH_BSLASH) ph = P_ESC_TOP;
					else begin
						kind = int'(KIND_CHAR);
						ch = b;
					end
				end
				P_ESC_TOP: begin
					kind = int'(KIND_CHAR);
					ch = b;
					ph = P_IDLE;
				end
				P_OPEN: begin
					if (b == CH_BANG) begin
						neg = 1'b1;
						ph = P_FIRST;
					end else start_member(b);
				end
				P_FIRST: start_member(b);
				P_TAIL, P_PEND: begin
					if (ph == P_PEND && b == CH_DASH) ph = P_RLAST;
					else begin
						if (ph == P_PEND) cset[rstart] = 1'b1;
						if (b == CH_CLOSE) begin
							ph = P_IDLE;
							kind = neg ? int'(KIND_NEG) : int'(KIND_CLASS);
						end else start_member(b);
					end
				end
				P_ESC_MEM: begin
					rstart = b;
					ph = P_PEND;
				end
				P_RLAST: begin
					if (b == CH_BSLASH) ph = P_ESC_LAST;
					else end_range(b);
				end
				default: end_range(b);
			endcase
		end
		if (fin && ok && ph != P_IDLE) ok = 1'b0;
		if (!ok) kind = -1;
		a = '0;
		if (kind < 0 && !fin) return 1'b0;
		if (kind >= 0) begin
			a.present = 1'b1;
			a.kind = kind[2:0];
			a.ch = ch;
			if (kind == KIND_CLASS || kind == KIND_NEG) a.set = cset;
		end
		if (fin) begin
			a.fin = 1'b1;
			a.ok = ok;
			ph = P_IDLE;
			neg = 1'b0;
			rstart = 8'h00;
			ok = 1'b1;
		end
		return 1'b1;
	endfunction

	// Result checking at the rising edge
	always @(posedge clk) begin
		atom_t got, w;
		if (arst_n && pop && !empty) begin
			got = {atom_present, atom_kind, atom_char,
				{set_bits_3, set_bits_2, set_bits_1, set_bits_0}, name_end, name_valid};
			if (atoms_due.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				errors++;
			end else begin
				w = atoms_due.pop_front();
				n_atoms++;
				if (got.present !== w.present || got.kind !== w.kind || got.ch !== w.ch ||
						got.set !== w.set || got.fin !== w.fin || got.ok !== w.ok) begin
					$display("%0t: mismatch expected %h actual %h", $time, w, got);
					errors++;
				end
			end
		end
	end

	// Receiver stalls on its own pattern, with stall-free stretches
	int rx_cnt = 0;
	always @(negedge clk) begin
		rx_cnt++;
		if ((rx_cnt / 200) % 3 == 2) pop <= 1'b1;
		else pop <= ($urandom_range(0, 3) != 0);
	end

	int burst = 0;

	// Sends one item: hold until accepted, queue the expectation
	task automatic send(logic [7:0] b, logic fin, logic chk, atom_t want);
		atom_t a;
		bit due;
		int gap;
		if (burst == 0) begin
			gap = $urandom_range(0, 3);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst = $urandom_range(1, 12);
		end
		burst--;
		push <= 1'b1;
		char_byte <= b;
		final_byte <= fin;
		@(posedge clk);
		while (full) @(posedge clk);
		due = parse_byte(b, fin, a);
		if (chk && (!due || a !== want)) begin
			$display("%0t: predictor disagrees with table, expected %h actual %h",
				$time, want, a);
			errors++;
		end
		if (due) atoms_due = {atoms_due, a};
		n_items++;
		if (fin) n_names++;
		@(negedge clk);
	endtask

	// Lets the sender go quiet, then waits until every due result has come
	task automatic drain();
		push <= 1'b0;
		@(negedge clk);
		while (atoms_due.size() != 0) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_member();
		case ($urandom_range(0, 5))
			0: return CH_CLOSE;
			1: return CH_BSLASH;
			2: return CH_DASH;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic send_noise(int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 2) == 0) b = rand_member();
			send(b, i == len - 1, 1'b0, '0);
		end
	endtask

	// Builds a mostly well-formed name in a byte queue and sends it
	task automatic send_good_name();
		logic [7:0] s[$];
		logic [7:0] x, y;
		int n;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 5))
				0: s = {s, CH_QUESTION};
				1: s = {s, CH_STAR};
				2: begin
					s = {s, CH_BSLASH};
					s = {s, 8'($urandom_range(0, 255))};
				end
				3, 4: begin
					s = {s, CH_OPEN};
					if ($urandom_range(0, 1)) s = {s, CH_BANG};
					for (int m = $urandom_range(1, 3); m > 0; m--) begin
						x = 8'($urandom_range(0, 255));
						y = 8'($urandom_range(0, 255));
						if ($urandom_range(0, 9) != 0 && sgn(x) > sgn(y)) {x, y} = {y, x};
						if (x == CH_BSLASH || $urandom_range(0, 5) == 0) s = {s, CH_BSLASH};
						else if (m != 0 && s[$] != CH_OPEN && s[$] != CH_BANG && x == CH_CLOSE)
							s = {s, CH_BSLASH};
						s = {s, x};
						if ($urandom_range(0, 1)) begin
							s = {s, CH_DASH};
							if (y == CH_BSLASH || $urandom_range(0, 5) == 0)
								s = {s, CH_BSLASH};
							s = {s, y};
						end
					end
					if ($urandom_range(0, 15) != 0) s = {s, CH_CLOSE};
				end
				default: begin
					x = 8'($urandom_range(0, 255));
					if (x inside {CH_QUESTION, CH_STAR, CH_OPEN, CH_BSLASH}) x = 8'h41;
					s = {s, x};
				end
			endcase
		end
		if ($urandom_range(0, 20) == 0) s = {s, CH_BSLASH};
		foreach (s[i]) send(s[i], i == s.size() - 1, 1'b0, '0);
	endtask

	function automatic atom_t mk(logic p, logic [2:0] k, logic [7:0] c, logic f, logic v);
		atom_t a;
		a = '0;
		a.present = p;
		a.kind = k;
		a.ch = c;
		a.fin = f;
		a.ok = v;
		return a;
	endfunction

	row_t dir_rows[$];

	task automatic add(logic [7:0] b, logic fin, logic chk = 1'b0, atom_t want = '0);
		row_t r;
		r.b = b;
		r.fin = fin;
		r.chk = chk;
		r.want = want;
		dir_rows = {dir_rows, r};
	endtask

	initial begin
		ph = P_IDLE;
		neg = 1'b0;
		ok = 1'b1;
		rstart = 8'h00;
		cset = '0;
		// directed table
		add(8'h00, 1'b0, 1'b1, mk(1'b1, KIND_CHAR, 8'h00, 1'b0, 1'b0));
		add(8'hFF, 1'b0, 1'b1, mk(1'b1, KIND_CHAR, 8'hFF, 1'b0, 1'b0));
		add(CH_QUESTION, 1'b0, 1'b1, mk(1'b1, KIND_WILD, 8'h00, 1'b0, 1'b0));
		add(CH_STAR, 1'b1, 1'b1, mk(1'b1, KIND_GLOB, 8'h00, 1'b1, 1'b1));
		add(CH_BSLASH, 1'b0);
		add(CH_STAR, 1'b1, 1'b1, mk(1'b1, KIND_CHAR, CH_STAR, 1'b1, 1'b1));
		// class with literal ']' first and full signed range 0x80..0x7F
		add(CH_OPEN, 1'b0); add(CH_CLOSE, 1'b0); add(8'h80, 1'b0); add(CH_DASH, 1'b0);
		add(8'h7F, 1'b0); add(CH_CLOSE, 1'b1);
		// negated class with escaped members
		add(CH_OPEN, 1'b0); add(CH_BANG, 1'b0); add(CH_BSLASH, 1'b0); add(CH_CLOSE, 1'b0);
		add(CH_DASH, 1'b0); add(CH_BSLASH, 1'b0); add(8'hFF, 1'b0); add(CH_CLOSE, 1'b1);
		// reversed range, then unfinished class, then trailing backslash
		add(CH_OPEN, 1'b0); add(8'h01, 1'b0); add(CH_DASH, 1'b0); add(8'hFF, 1'b0);
		add(CH_CLOSE, 1'b1, 1'b1, mk(1'b0, KIND_CHAR, 8'h00, 1'b1, 1'b0));
		add(CH_OPEN, 1'b1, 1'b1, mk(1'b0, KIND_CHAR, 8'h00, 1'b1, 1'b0));
		add(CH_BSLASH, 1'b1, 1'b1, mk(1'b0, KIND_CHAR, 8'h00, 1'b1, 1'b0));

		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		foreach (dir_rows[i]) send(dir_rows[i].b, dir_rows[i].fin, dir_rows[i].chk,
			dir_rows[i].want);

		// random names, mostly well formed
		while (n_items < 800) begin
			if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 8));
			else send_good_name();
			if (n_names == 40) begin
				// hold off until the block has drained
				drain();
				send_good_name();
			end
		end

		drain();
		repeat (20) @(negedge clk);
		$display("Sent %0d bytes in %0d names; %0d results checked.",
			n_items, n_names, n_atoms);
		if (errors == 0) $display("PASSED: all results match");
		else $display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end
endmodule
